>>> hdl/btwg_pkg.sv
package btwg_pkg;

  localparam int MAX_AXIS         = 4096;
  localparam int COORD_FRAC_BITS  = 8;
  localparam int WEIGHT_FRAC_BITS = 14;

  localparam int COORD_W = 21;
  localparam int SIZE_W  = 13;
  localparam int IDX_W   = 12;
  localparam int WGT_W   = 16;
  localparam int COEFF_W = 15;
  localparam int LANES   = 4;

  localparam int FLOOR_W    = COORD_W - COORD_FRAC_BITS;
  localparam int IDX_CALC_W = FLOOR_W + 1;
  localparam int DIST_W     = COORD_FRAC_BITS + 2;
  localparam int P_W        = WEIGHT_FRAC_BITS + 10;
  localparam int PROD_W     = P_W + DIST_W + 1;

  localparam int ONE_C      = 1 << COORD_FRAC_BITS;
  localparam int ONE_W      = 1 << WEIGHT_FRAC_BITS;
  localparam int ROUND_HALF = 1 << (COORD_FRAC_BITS - 1);
  localparam int WGT_MAX    = (1 << (WGT_W - 1)) - 1;
  localparam int WGT_MIN    = -(1 << (WGT_W - 1));

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_A = REG_IDX_W'(0);
  localparam int COEFF_RESET = -8192;

  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef logic signed [P_W-1:0] poly_t;

  typedef enum logic [1:0] {
    CLS_INNER,
    CLS_OUTER,
    CLS_ZERO
  } dist_cls_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] source_coord;
    logic [SIZE_W-1:0]         axis_size;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        tap_index0;
    logic [IDX_W-1:0]        tap_index1;
    logic [IDX_W-1:0]        tap_index2;
    logic [IDX_W-1:0]        tap_index3;
    logic signed [WGT_W-1:0] tap_weight0;
    logic signed [WGT_W-1:0] tap_weight1;
    logic signed [WGT_W-1:0] tap_weight2;
    logic signed [WGT_W-1:0] tap_weight3;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] span;
    dist_cls_e         cls;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
  } q_entry_t;

  // p*x with x holding COORD_FRAC_BITS fraction bits, round half up
  function automatic poly_t mul_round(poly_t p, logic [DIST_W-1:0] x);
    logic signed [PROD_W-1:0] prod;
    prod = PROD_W'(p) * $signed({1'b0, x});
    prod = prod + PROD_W'(ROUND_HALF);
    return P_W'(prod >>> COORD_FRAC_BITS);
  endfunction

  function automatic logic signed [WGT_W-1:0] sat_wgt(poly_t p);
    if (p > P_W'(WGT_MAX)) begin
      return WGT_W'(WGT_MAX);
    end else if (p < P_W'(WGT_MIN)) begin
      return WGT_W'(WGT_MIN);
    end
    return WGT_W'(p);
  endfunction

endpackage

>>> hdl/bicubic_tap_weight_generator_core.sv
// Bicubic tap and weight generator (Keys cubic convolution kernel).
// Input: pulse start with src_i (source coordinate, 8 fraction bits, and
// axis size); the beat is taken at an edge where start is high and busy low.
// busy only rises if the internal queue fills, which does not happen in
// normal operation, so one beat per cycle is taken.
// Output: res_valid_o is high for one cycle with res_o holding four clamped
// tap indices and four Q2.14 weights. The receiver cannot hold results off.
// Path: each beat is classified into a 2-entry queue, then passes three
// Horner multiply stages and saturation before res_valid_o rises.
// Throughput: one beat per cycle, set by the fully pipelined Horner lanes.
// Config: APB register 0 at byte address 0 holds the kernel coefficient a
// (15-bit signed Q1.14); write it only while no beat is in flight.
// Reset: asynchronous, active low; clears the queue and pipeline valids and
// loads a = -0.5.
module bicubic_tap_weight_generator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  btwg_pkg::in_item_t                   src_i,
  output logic                                 res_valid_o,
  output btwg_pkg::out_item_t                  res_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [btwg_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [btwg_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [btwg_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import btwg_pkg::*;

  coeff_t   coeff_q;
  logic     reg_hit;
  logic     cfg_wr;
  logic     full;
  logic     push;
  logic     pop;
  logic     head_valid;
  q_entry_t entry;
  q_entry_t head;

  assign pready  = 1'b1;
  assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_KERNEL_A;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_hit ? APB_DATA_W'(coeff_q) : '0;
  assign busy    = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= COEFF_W'(COEFF_RESET);
    end else if (cfg_wr && reg_hit) begin
      coeff_q <= pwdata[COEFF_W-1:0];
    end
  end

  btwg_front u_front (
    .start_valid_i (start),
    .full_i        (full),
    .src_i         (src_i),
    .push_o        (push),
    .entry_o       (entry)
  );

  btwg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  btwg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coeff_i      (coeff_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

endmodule

>>> hdl/btwg_front.sv
module btwg_front (
  input  logic               start_valid_i,
  input  logic               full_i,
  input  btwg_pkg::in_item_t src_i,
  output logic               push_o,
  output btwg_pkg::q_entry_t entry_o
);
  import btwg_pkg::*;

  logic signed [FLOOR_W-1:0]    floor_v;
  logic [COORD_FRAC_BITS-1:0]   frac_v;
  logic signed [IDX_CALC_W-1:0] size_m1;
  logic signed [IDX_CALC_W-1:0] tap_pos [LANES];
  logic [DIST_W-1:0]            lane_span [LANES];

  assign push_o  = start_valid_i && !full_i;
  assign floor_v = FLOOR_W'(src_i.source_coord >>> COORD_FRAC_BITS);
  assign frac_v  = src_i.source_coord[COORD_FRAC_BITS-1:0];

  always_comb begin
    if (src_i.axis_size == '0) begin
      size_m1 = '0;
    end else if (src_i.axis_size > SIZE_W'(MAX_AXIS)) begin
      size_m1 = IDX_CALC_W'(MAX_AXIS - 1);
    end else begin
      size_m1 = IDX_CALC_W'(src_i.axis_size) - IDX_CALC_W'(1);
    end
  end

  always_comb begin
    lane_span[0] = DIST_W'(ONE_C) + DIST_W'(frac_v);
    lane_span[1] = DIST_W'(frac_v);
    lane_span[2] = DIST_W'(ONE_C) - DIST_W'(frac_v);
    lane_span[3] = DIST_W'(2 * ONE_C) - DIST_W'(frac_v);
    for (int k = 0; k < LANES; k++) begin
      tap_pos[k] = IDX_CALC_W'(floor_v) + IDX_CALC_W'(k - 1);
      if (tap_pos[k] < 0) begin
        entry_o.lane[k].idx = '0;
      end else if (tap_pos[k] > size_m1) begin
        entry_o.lane[k].idx = IDX_W'(size_m1);
      end else begin
        entry_o.lane[k].idx = IDX_W'(tap_pos[k]);
      end
      entry_o.lane[k].span = lane_span[k];
      if (lane_span[k] <= DIST_W'(ONE_C)) begin
        entry_o.lane[k].cls = CLS_INNER;
      end else if (lane_span[k] <= DIST_W'(2 * ONE_C)) begin
        entry_o.lane[k].cls = CLS_OUTER;
      end else begin
        entry_o.lane[k].cls = CLS_ZERO;
      end
    end
  end

endmodule

>>> hdl/btwg_queue.sv
module btwg_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  btwg_pkg::q_entry_t entry_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               head_valid_o,
  output btwg_pkg::q_entry_t head_o
);
  import btwg_pkg::*;

  q_entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_pop;

  assign full_o       = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> hdl/btwg_back.sv
module btwg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btwg_pkg::coeff_t    coeff_i,
  input  logic                head_valid_i,
  input  btwg_pkg::q_entry_t  head_i,
  output logic                pop_o,
  output logic                res_valid_o,
  output btwg_pkg::out_item_t res_o
);
  import btwg_pkg::*;

  poly_t a_x;
  poly_t c_in3, c_in2, c_in0;
  poly_t c_out3, c_out2, c_out1, c_out0;
  poly_t c3_sel [LANES];
  poly_t c2_sel [LANES];
  poly_t c1_sel [LANES];
  poly_t c0_sel [LANES];

  poly_t                   pa_q [LANES];
  poly_t                   pb_q [LANES];
  poly_t                   pc_q [LANES];
  logic [DIST_W-1:0]       xa_q [LANES];
  logic [DIST_W-1:0]       xb_q [LANES];
  dist_cls_e               cla_q [LANES];
  dist_cls_e               clb_q [LANES];
  dist_cls_e               clc_q [LANES];
  logic [IDX_W-1:0]        ia_q [LANES];
  logic [IDX_W-1:0]        ib_q [LANES];
  logic [IDX_W-1:0]        ic_q [LANES];
  logic [IDX_W-1:0]        io_q [LANES];
  logic signed [WGT_W-1:0] w_q [LANES];
  logic                    va_q, vb_q, vc_q, vo_q;

  assign pop_o = head_valid_i;

  // Keys kernel coefficients, inner: a+2, -(a+3), 0, 1; outer: a, -5a, 8a, -4a
  assign a_x    = P_W'(coeff_i);
  assign c_in3  = a_x + P_W'(2 * ONE_W);
  assign c_in2  = -(a_x + P_W'(3 * ONE_W));
  assign c_in0  = P_W'(ONE_W);
  assign c_out3 = a_x;
  assign c_out2 = -((a_x <<< 2) + a_x);
  assign c_out1 = a_x <<< 3;
  assign c_out0 = -(a_x <<< 2);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      c3_sel[k] = (head_i.lane[k].cls == CLS_OUTER) ? c_out3 : c_in3;
      c2_sel[k] = (head_i.lane[k].cls == CLS_OUTER) ? c_out2 : c_in2;
      c1_sel[k] = (cla_q[k] == CLS_OUTER) ? c_out1 : '0;
      c0_sel[k] = (clb_q[k] == CLS_OUTER) ? c_out0 : c_in0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANES; k++) begin
      pa_q[k]  <= mul_round(c3_sel[k], head_i.lane[k].span) + c2_sel[k];
      xa_q[k]  <= head_i.lane[k].span;
      cla_q[k] <= head_i.lane[k].cls;
      ia_q[k]  <= head_i.lane[k].idx;

      pb_q[k]  <= mul_round(pa_q[k], xa_q[k]) + c1_sel[k];
      xb_q[k]  <= xa_q[k];
      clb_q[k] <= cla_q[k];
      ib_q[k]  <= ia_q[k];

      pc_q[k]  <= mul_round(pb_q[k], xb_q[k]) + c0_sel[k];
      clc_q[k] <= clb_q[k];
      ic_q[k]  <= ib_q[k];

      w_q[k]   <= (clc_q[k] == CLS_ZERO) ? '0 : sat_wgt(pc_q[k]);
      io_q[k]  <= ic_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      va_q <= head_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vo_q <= vc_q;
    end
  end

  assign res_valid_o = vo_q;

  always_comb begin
    res_o.tap_index0  = io_q[0];
    res_o.tap_index1  = io_q[1];
    res_o.tap_index2  = io_q[2];
    res_o.tap_index3  = io_q[3];
    res_o.tap_weight0 = w_q[0];
    res_o.tap_weight1 = w_q[1];
    res_o.tap_weight2 = w_q[2];
    res_o.tap_weight3 = w_q[3];
  end

endmodule

>>> hdl/btwg_checker.sv
module btwg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            res_valid_o,
  input btwg_pkg::out_item_t             res_o,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [btwg_pkg::APB_ADDR_W-1:0] paddr,
  input logic [btwg_pkg::APB_DATA_W-1:0] pwdata,
  input logic [btwg_pkg::APB_DATA_W-1:0] prdata,
  input logic                            pready
);
  import btwg_pkg::*;

  a_beat_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 res_valid_o)
    else $error("accepted beat produced no result");

  a_result_from_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, 5))
    else $error("result without matching beat");

  a_taps_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.tap_index0 <= res_o.tap_index1) &&
                    (res_o.tap_index1 <= res_o.tap_index2) &&
                    (res_o.tap_index2 <= res_o.tap_index3))
    else $error("tap indices out of order");

  a_coeff_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) |=>
      (paddr[2] || prdata[COEFF_W-1:0] == $past(pwdata[COEFF_W-1:0])))
    else $error("coefficient readback mismatch");

endmodule

bind bicubic_tap_weight_generator_core btwg_checker u_btwg_checker (.*);
